FILE: src/frrd_pkg.sv
// Shared types, constants and helpers for the four-queue round-robin drain.
// Used by frrd_store and four_queue_round_robin_drain; no dependencies.
package frrd_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 4;
    localparam int QSEL_W      = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = QSEL_W + PTR_W;
    localparam int STORE_DEPTH = NUM_QUEUES << PTR_W;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int DIR_W    = 3;
    localparam int ID_W     = 10;
    localparam int STATUS_W = 3;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_SET_DIR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_WEST  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NORTH = 3'd3;
    localparam logic [DIR_W-1:0] DIR_EAST  = 3'd4;

    // Queue indexes in service order
    localparam logic [QSEL_W-1:0] Q_WEST  = 2'd0;
    localparam logic [QSEL_W-1:0] Q_NORTH = 2'd1;
    localparam logic [QSEL_W-1:0] Q_SOUTH = 2'd2;
    localparam logic [QSEL_W-1:0] Q_EAST  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NODIR    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DIRSET   = 3'd5;

    // Write and read request to the id store
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ID_W-1:0]   wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_store_req;

    // Map a direction code onto its queue; none maps to west
    function automatic logic [QSEL_W-1:0] dir_to_queue(input logic [DIR_W-1:0] dir);
        logic [QSEL_W-1:0] q;
        case (dir)
            DIR_SOUTH: q = Q_SOUTH;
            DIR_NORTH: q = Q_NORTH;
            DIR_EAST:  q = Q_EAST;
            default:   q = Q_WEST;
        endcase
        return q;
    endfunction

    // Advance a slot pointer with wrap at the queue depth
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

FILE: src/frrd_store.sv
// Id store for all four queues: one write port, one registered read port.
// Depends on frrd_pkg for geometry and the request struct.
module frrd_store (
    input  logic                  i_clk,
    input  frrd_pkg::t_store_req  i_req,
    output logic [frrd_pkg::ID_W-1:0] o_rd_data
);
    import frrd_pkg::*;

    logic [ID_W-1:0] r_mem [STORE_DEPTH];
    logic [ID_W-1:0] r_rd_data;

    // Write a pushed id
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read a popped id; hold otherwise so a stalled result keeps its id
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/four_queue_round_robin_drain.sv
// Four-queue round-robin drain: top level with queue control and result stage.
// Depends on frrd_pkg and frrd_store.
//
//  channel   valid          stall          beat fields
//  input     i_in_valid     o_in_stall     i_mode, i_direction, i_aircraft_id
//  output    o_out_valid    i_out_stall    o_status, o_aircraft_id_res, o_queue_served
//
// One beat per cycle while the output is not stalled; a result passes the input register,
// then the result register with the store's registered read port.
// Mode 3 beats are taken and discarded at the input register, giving no result.
// Reset (synchronous, active low) empties all queues, clears the direction to none
// and points the round robin at west; the id store itself is not cleared.
// A stall on the output holds the result register and backs up into o_in_stall.
module four_queue_round_robin_drain (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [frrd_pkg::MODE_W-1:0]     i_mode,
    input  logic [frrd_pkg::DIR_W-1:0]      i_direction,
    input  logic [frrd_pkg::ID_W-1:0]       i_aircraft_id,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [frrd_pkg::STATUS_W-1:0]   o_status,
    output logic [frrd_pkg::ID_W-1:0]       o_aircraft_id_res,
    output logic [frrd_pkg::QSEL_W-1:0]     o_queue_served
);
    import frrd_pkg::*;

    // Input register
    logic              r_in_valid;
    logic [MODE_W-1:0] r_mode;
    logic [DIR_W-1:0]  r_dir_in;
    logic [ID_W-1:0]   r_id;

    // Queue state
    logic [PTR_W-1:0]  r_head [NUM_QUEUES];
    logic [PTR_W-1:0]  r_tail [NUM_QUEUES];
    logic [CNT_W-1:0]  r_count [NUM_QUEUES];
    logic [DIR_W-1:0]  r_dir;
    logic [QSEL_W-1:0] r_rr;
    logic [PTR_W-1:0]  n_head [NUM_QUEUES];
    logic [PTR_W-1:0]  n_tail [NUM_QUEUES];
    logic [CNT_W-1:0]  n_count [NUM_QUEUES];
    logic [DIR_W-1:0]  n_dir;
    logic [QSEL_W-1:0] n_rr;

    // Result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [QSEL_W-1:0]   r_served;
    logic [STATUS_W-1:0] n_status;
    logic [QSEL_W-1:0]   n_served;

    logic              out_adv;
    logic              proc;
    logic              in_adv;
    logic              pop_found;
    logic [QSEL_W-1:0] pop_q;
    logic [QSEL_W-1:0] enq_q;
    t_store_req        store_req;
    logic [ID_W-1:0]   rd_data;

    // Handshake: the result slot frees when empty or taken
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_adv;
    assign in_adv     = !r_in_valid || proc;
    assign o_in_stall = !in_adv;

    // Capture input beats; drop ignored modes here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_in_valid && (i_mode != MODE_IGNORED);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_mode   <= i_mode;
            r_dir_in <= i_direction;
            r_id     <= i_aircraft_id;
        end
    end

    // Find the first non-empty queue from the round-robin pointer
    always_comb begin
        logic [QSEL_W-1:0] cand;
        pop_found = 1'b0;
        pop_q     = '0;
        for (int k = 0; k < NUM_QUEUES; k++) begin
            cand = r_rr + QSEL_W'(k);
            if (!pop_found && (r_count[cand] != '0)) begin
                pop_found = 1'b1;
                pop_q     = cand;
            end
        end
    end

    assign enq_q = dir_to_queue(r_dir);

    // Execute the item in the input register
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_dir     = r_dir;
        n_rr      = r_rr;
        n_status  = ST_EMPTY;
        n_served  = Q_WEST;
        store_req = '0;
        if (proc) begin
            case (r_mode)
                MODE_SET_DIR: begin
                    n_dir    = (r_dir_in inside {[DIR_WEST:DIR_EAST]}) ? r_dir_in : DIR_NONE;
                    n_status = ST_DIRSET;
                    n_served = dir_to_queue(n_dir);
                end
                MODE_ENQUEUE: begin
                    if (r_dir == DIR_NONE) begin
                        n_status = ST_NODIR;
                    end else begin
                        n_served = enq_q;
                        if (r_count[enq_q] == CNT_W'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            store_req.wr_en   = 1'b1;
                            store_req.wr_addr = {enq_q, r_tail[enq_q]};
                            store_req.wr_data = r_id;
                            n_tail[enq_q]     = next_slot(r_tail[enq_q]);
                            n_count[enq_q]    = r_count[enq_q] + 1'b1;
                            n_status          = ST_ENQUEUED;
                        end
                    end
                end
                MODE_POP: begin
                    if (pop_found) begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = {pop_q, r_head[pop_q]};
                        n_head[pop_q]     = next_slot(r_head[pop_q]);
                        n_count[pop_q]    = r_count[pop_q] - 1'b1;
                        n_rr              = pop_q + 1'b1;
                        n_served          = pop_q;
                        n_status          = ST_POPPED;
                    end
                end
                default: begin
                    n_status = ST_EMPTY;
                end
            endcase
        end
    end

    // Hold queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q]  <= '0;
                r_tail[q]  <= '0;
                r_count[q] <= '0;
            end
            r_dir <= DIR_NONE;
            r_rr  <= Q_WEST;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_dir   <= n_dir;
            r_rr    <= n_rr;
        end
    end

    // Advance the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_status <= n_status;
            r_served <= n_served;
        end
    end

    frrd_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_queue_served    = r_served;
    assign o_aircraft_id_res = (r_status == ST_POPPED) ? rd_data : '0;

endmodule

FILE: test/four_queue_round_robin_drain_tb.sv
// Self-checking testbench for four_queue_round_robin_drain: drives directed and random
// traffic, predicts each result in its own queue model and compares the output beats.
// Depends on frrd_pkg and the RTL under src/.
module four_queue_round_robin_drain_tb;
    import frrd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DIR_W-1:0]  dir;
        logic [ID_W-1:0]   id;
    } t_traffic_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [QSEL_W-1:0]   served;
    } t_tower_result;

    // DUT connections, all inputs known from time zero
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [MODE_W-1:0]   i_mode = MODE_POP;
    logic [DIR_W-1:0]    i_direction = DIR_NONE;
    logic [ID_W-1:0]     i_aircraft_id = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_aircraft_id_res;
    logic [QSEL_W-1:0]   o_queue_served;

    four_queue_round_robin_drain dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_direction       (i_direction),
        .i_aircraft_id     (i_aircraft_id),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_aircraft_id_res (o_aircraft_id_res),
        .o_queue_served    (o_queue_served)
    );

    // Stimulus and expectation stores
    t_traffic_beat pending_beats[$];
    t_tower_result expected_results[$];
    t_traffic_beat next_beat;

    // Queue model of the block
    logic [ID_W-1:0]   id_slots [NUM_QUEUES][QUEUE_DEPTH];
    int                slot_rd [NUM_QUEUES] = '{0, 0, 0, 0};
    int                slot_wr [NUM_QUEUES] = '{0, 0, 0, 0};
    int                fill_level [NUM_QUEUES] = '{0, 0, 0, 0};
    logic [DIR_W-1:0]  steer_dir = DIR_NONE;
    logic [QSEL_W-1:0] next_pick = Q_WEST;

    // Traffic shaping knobs; rates and hold toggle set by the sequencer, hold state by the stall driver
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_toggle = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    // Run statistics
    int error_count = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int pops_seen = 0;
    int full_drops = 0;
    int nodir_drops = 0;
    int ignored_beats = 0;
    int cycle_count = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Map a direction code onto the queue it feeds
    function automatic logic [QSEL_W-1:0] queue_of(input logic [DIR_W-1:0] dir);
        case (dir)
            DIR_SOUTH: return Q_SOUTH;
            DIR_NORTH: return Q_NORTH;
            DIR_EAST:  return Q_EAST;
            default:   return Q_WEST;
        endcase
    endfunction

    // Mostly legal ids, with the unused top of the range now and then
    function automatic logic [ID_W-1:0] random_id();
        if ($urandom_range(9) == 0) begin
            return ID_W'($urandom_range(1023, 1000));
        end
        return ID_W'($urandom_range(999, 0));
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s: expected %0d, got %0d (result %0d)", what, want, got,
                 results_seen);
        error_count++;
    endtask

    // Apply one accepted beat to the queue model and queue its result
    task automatic predict_tower_result(input t_traffic_beat b);
        t_tower_result     r;
        logic [QSEL_W-1:0] q;
        bit                found;
        r = '0;
        found = 1'b0;
        case (b.mode)
            MODE_SET_DIR: begin
                steer_dir = (b.dir inside {[DIR_WEST:DIR_EAST]}) ? b.dir : DIR_NONE;
                r.status = ST_DIRSET;
                r.served = (steer_dir != DIR_NONE) ? queue_of(steer_dir) : Q_WEST;
            end
            MODE_ENQUEUE: begin
                if (steer_dir == DIR_NONE) begin
                    r.status = ST_NODIR;
                end else begin
                    q = queue_of(steer_dir);
                    r.served = q;
                    if (fill_level[q] >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        id_slots[q][slot_wr[q]] = b.id;
                        slot_wr[q] = (slot_wr[q] + 1) % QUEUE_DEPTH;
                        fill_level[q]++;
                        r.status = ST_ENQUEUED;
                    end
                end
            end
            MODE_POP: begin
                // search starts after the queue served last
                r.status = ST_EMPTY;
                for (int k = 0; k < NUM_QUEUES; k++) begin
                    q = QSEL_W'(next_pick + k);
                    if (!found && fill_level[q] != 0) begin
                        found = 1'b1;
                        r.status = ST_POPPED;
                        r.id = id_slots[q][slot_rd[q]];
                        r.served = q;
                        slot_rd[q] = (slot_rd[q] + 1) % QUEUE_DEPTH;
                        fill_level[q]--;
                        next_pick = q + 1'b1;
                    end
                end
            end
            default: begin
                ignored_beats++;
            end
        endcase
        if (b.mode != MODE_IGNORED) begin
            expected_results.push_back(r);
        end
    endtask

    // Compare one output beat with the oldest expectation
    task automatic check_tower_result();
        t_tower_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, status", -1, o_status);
            return;
        end
        want = expected_results.pop_front();
        if (o_status !== want.status) report_mismatch("status", want.status, o_status);
        if (o_aircraft_id_res !== want.id) report_mismatch("aircraft id", want.id, o_aircraft_id_res);
        if (o_queue_served !== want.served) report_mismatch("queue", want.served, o_queue_served);
        if (want.status == ST_POPPED) pops_seen++;
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_NODIR) nodir_drops++;
        results_seen++;
    endtask

    task automatic push_beat(input logic [MODE_W-1:0] mode, input logic [DIR_W-1:0] dir,
                             input logic [ID_W-1:0] id);
        pending_beats.push_back('{mode: mode, dir: dir, id: id});
    endtask

    // Random traffic: direction plus enqueue runs, pop runs, fill bursts and noise
    task automatic add_random_traffic(input int n_beats);
        int               added;
        int               kind;
        int               len;
        logic [MODE_W-1:0] m;
        added = 0;
        while (added < n_beats) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                push_beat(MODE_SET_DIR, DIR_W'($urandom_range(int'(DIR_EAST), int'(DIR_WEST))),
                          random_id());
                len = $urandom_range(6, 1);
                repeat (len) push_beat(MODE_ENQUEUE, DIR_W'($urandom_range(7)), random_id());
                added += len + 1;
            end else if (kind < 80) begin
                len = $urandom_range(10, 1);
                repeat (len) push_beat(MODE_POP, DIR_W'($urandom_range(7)), random_id());
                added += len;
            end else if (kind < 85) begin
                push_beat(MODE_SET_DIR, DIR_W'($urandom_range(int'(DIR_EAST), int'(DIR_WEST))),
                          random_id());
                len = $urandom_range(20, 16);
                repeat (len) push_beat(MODE_ENQUEUE, DIR_W'($urandom_range(7)), random_id());
                added += len + 1;
            end else begin
                m = MODE_W'($urandom_range(3));
                push_beat(m, DIR_W'($urandom_range(7)), ID_W'($urandom_range(1023)));
                if (m != MODE_IGNORED) added++;
            end
        end
    endtask

    // Hold off new traffic until every beat is sent and every result is back
    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Sequencer: directed beats, pressure burst, then the random phases with idling and stalls
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_beat(MODE_POP, DIR_NONE, '0);
        push_beat(MODE_ENQUEUE, DIR_WEST, 10'd5);
        push_beat(MODE_IGNORED, 3'd7, 10'd1023);
        push_beat(MODE_SET_DIR, 3'd7, '0);
        push_beat(MODE_ENQUEUE, DIR_EAST, 10'd6);
        push_beat(MODE_SET_DIR, 3'd5, '0);
        push_beat(MODE_SET_DIR, 3'd6, 10'd1023);
        push_beat(MODE_SET_DIR, DIR_WEST, '0);
        push_beat(MODE_ENQUEUE, DIR_NONE, 10'd0);
        push_beat(MODE_ENQUEUE, 3'd7, 10'd1023);
        push_beat(MODE_SET_DIR, DIR_SOUTH, '0);
        push_beat(MODE_ENQUEUE, DIR_NONE, 10'd999);
        push_beat(MODE_SET_DIR, DIR_NORTH, '0);
        push_beat(MODE_ENQUEUE, DIR_NONE, 10'h155);
        push_beat(MODE_SET_DIR, DIR_EAST, '0);
        push_beat(MODE_ENQUEUE, DIR_NONE, 10'h2AA);
        push_beat(MODE_ENQUEUE, DIR_NONE, 10'd1000);
        repeat (7) push_beat(MODE_POP, DIR_NONE, '0);
        push_beat(MODE_SET_DIR, DIR_NONE, '0);
        wait_drained();

        // Long output hold while east overflows and pops keep arriving
        hold_toggle = ~hold_toggle;
        push_beat(MODE_SET_DIR, DIR_EAST, '0);
        repeat (20) push_beat(MODE_ENQUEUE, DIR_NONE, random_id());
        repeat (20) push_beat(MODE_POP, DIR_NONE, '0);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            add_random_traffic(190);
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch("results never delivered", 0, expected_results.size());
        end
        $display("summary: %0d beats sent (%0d mode 3), %0d results checked", beats_sent,
                 ignored_beats, results_seen);
        $display("summary: %0d pops, %0d full drops, %0d no-direction drops, %0d errors",
                 pops_seen, full_drops, nodir_drops, error_count);
        if (error_count == 0) begin
            $display("four_queue_round_robin_drain_tb: done, clean");
        end else begin
            $display("four_queue_round_robin_drain_tb: done, errors");
        end
        $finish;
    end

    // Input driver: predict each accepted beat, then offer the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_tower_result('{mode: i_mode, dir: i_direction, id: i_aircraft_id});
                beats_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat = pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode <= next_beat.mode;
                    i_direction <= next_beat.dir;
                    i_aircraft_id <= next_beat.id;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall: a requested long hold first, else random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_toggle;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            hold_left <= 0;
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_tower_result();
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_results.size());
            $display("four_queue_round_robin_drain_tb: done, errors");
            $finish;
        end
    end

endmodule
